>>> design/qwfd_pkg.sv
`timescale 1ns / 1ps
package qwfd_pkg;
    localparam logic [15:0] DEFAULT_NAN = 16'h7E00;
    localparam logic [15:0] QUIET_BIT   = 16'h0200;
    localparam logic [4:0]  EXP_ALL     = 5'h1F;
    localparam logic        MODE_BINARY = 1'b0;
    localparam logic        MODE_TERNARY = 1'b1;

    typedef struct packed {
        logic [15:0] term;
        logic        last;
    } t_term;
endpackage

>>> design/qwfd_term.sv
`timescale 1ns / 1ps
module qwfd_term (
    input  logic                i_mode,
    input  logic [15:0]         i_activation,
    input  logic [1:0]          i_weight_code,
    input  logic                i_last_element,
    output qwfd_pkg::t_term     o_term
);
    import qwfd_pkg::*;

    logic        sgn;
    logic [14:0] mag;

    always_comb begin
        if (i_mode == MODE_BINARY) begin
            sgn = i_activation[15] ^ i_weight_code[0];
            mag = i_activation[14:0];
        end else begin
            sgn = i_activation[15] ^ i_weight_code[1];
            mag = i_weight_code[0] ? i_activation[14:0] : 15'd0;
        end
        o_term.term = {sgn, mag};
        o_term.last = i_last_element;
    end
endmodule

>>> design/qwfd_add.sv
`timescale 1ns / 1ps
module qwfd_add (
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_sum
);
    import qwfd_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf;
    logic [4:0]  ea, eb, ea_eff;
    logic [10:0] ma, mb;
    logic        swap;
    logic [15:0] big, sml;
    logic [4:0]  eb_big, eb_sml, dsh;
    logic [13:0] mbig, msml_pre;
    logic [27:0] msml_wide;
    logic [13:0] msml;
    logic        sticky;
    logic        sub;
    logic [14:0] raw;
    logic [4:0]  lz;
    logic [14:0] norm;
    logic [5:0]  exp_n;
    logic [10:0] keep;
    logic        grd, rnd;
    logic [11:0] keep_r;
    logic [5:0]  exp_r;
    logic [9:0]  frac_r;

    always_comb begin
        ea    = i_a[14:10];
        eb    = i_b[14:10];
        a_nan = (ea == EXP_ALL) && (i_a[9:0] != 10'd0);
        b_nan = (eb == EXP_ALL) && (i_b[9:0] != 10'd0);
        a_inf = (i_a[14:0] == 15'h7C00);
        b_inf = (i_b[14:0] == 15'h7C00);
        swap   = i_b[14:0] > i_a[14:0];
        big    = swap ? i_b : i_a;
        sml    = swap ? i_a : i_b;
        eb_big = (big[14:10] == 5'd0) ? 5'd1 : big[14:10];
        eb_sml = (sml[14:10] == 5'd0) ? 5'd1 : sml[14:10];
        ma     = {big[14:10] != 5'd0, big[9:0]};
        mb     = {sml[14:10] != 5'd0, sml[9:0]};
        dsh    = eb_big - eb_sml;
        mbig   = {ma, 3'b000};
        msml_wide = {mb, 17'd0} >> dsh;
        msml_pre  = msml_wide[27:14];
        sticky    = (msml_wide[13:0] != 14'd0);
        msml   = {msml_pre[13:1], msml_pre[0] | sticky};
        sub    = big[15] ^ sml[15];
        raw    = sub ? ({1'b0, mbig} - {1'b0, msml}) : ({1'b0, mbig} + {1'b0, msml});
        ea_eff = eb_big;
        lz = 5'd0;
        for (int k = 13; k >= 0; k--) begin
            if (raw[14:0] < (15'd1 << (k + 1))) lz = 5'(14 - k);
        end
        if (raw[14]) begin
            norm  = {1'b0, raw[14:2], raw[1] | raw[0]};
            exp_n = {1'b0, ea_eff} + 6'd1;
        end else if ({1'b0, lz} - 6'd1 < {1'b0, ea_eff} || ea_eff > lz - 5'd1) begin
            norm  = raw << (lz - 5'd1);
            exp_n = {1'b0, ea_eff} - {1'b0, lz} + 6'd1;
        end else begin
            norm  = raw << (ea_eff - 5'd1);
            exp_n = 6'd0;
        end
        keep   = norm[13:3];
        grd    = norm[2];
        rnd    = norm[1] | norm[0];
        keep_r = {1'b0, keep} + {11'd0, grd & (rnd | keep[0])};
        exp_r  = (exp_n == 6'd0) ? {5'd0, keep[10]} : exp_n;
        frac_r = keep_r[9:0];
        if (keep_r[11]) begin
            exp_r  = exp_r + 6'd1;
            frac_r = keep_r[10:1];
        end else if (exp_n == 6'd0 && keep_r[10]) begin
            exp_r = 6'd1;
        end
        if (a_nan)                o_sum = i_a | QUIET_BIT;
        else if (b_nan)           o_sum = i_b | QUIET_BIT;
        else if (a_inf && b_inf)  o_sum = (i_a[15] == i_b[15]) ? i_a : DEFAULT_NAN;
        else if (a_inf)           o_sum = i_a;
        else if (b_inf)           o_sum = i_b;
        else if (raw == 15'd0)    o_sum = {i_a[15] & i_b[15], 15'd0};
        else if (exp_r >= 6'd31)  o_sum = {big[15], 15'h7C00};
        else                      o_sum = {big[15], exp_r[4:0], frac_r};
    end
endmodule

>>> design/quantized_weight_fp16_dot.sv
`timescale 1ns / 1ps
// Channel | Signals                                           | Direction
// input   | i_valid, o_stall, i_activation, i_weight_code,   | in
//         | i_last_element                                    |
// output  | o_valid, i_stall, o_dot_sum                       | out
// config  | i_cfg_valid, o_cfg_ready, i_cfg_data (weight_mode)| in
// One item per cycle while o_stall is low; a sum appears in the cycle after its last item is accepted.
// The combinational fp16 add into the accumulator sets the clock rate.
// Reset sets the accumulator to +0 and the mode to ternary.
// A waiting result holds in the output register while i_stall is high, and stalls input only then.
module quantized_weight_fp16_dot (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_activation,
    input  logic [1:0]  i_weight_code,
    input  logic        i_last_element,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_dot_sum,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import qwfd_pkg::*;

    logic        r_mode;
    logic [15:0] r_acc, n_acc;
    logic        r_valid;
    logic [15:0] r_sum;
    t_term       term;
    logic [15:0] sum;
    logic        accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_valid & i_stall;
    assign accept      = i_valid & ~o_stall;
    assign o_valid     = r_valid;
    assign o_dot_sum   = r_sum;

    qwfd_term u_term (
        .i_mode(r_mode), .i_activation(i_activation), .i_weight_code(i_weight_code),
        .i_last_element(i_last_element), .o_term(term)
    );
    qwfd_add u_add (.i_a(r_acc), .i_b(term.term), .o_sum(sum));

    always_comb begin
        n_acc = r_acc;
        if (accept) begin
            n_acc = term.last ? 16'd0 : sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TERNARY;
            r_acc   <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_acc <= n_acc;
            if (accept && term.last) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && term.last) begin
            r_sum <= sum;
        end
    end
endmodule

>>> design/qwfd_check.sv
`timescale 1ns / 1ps
module qwfd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_element,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_dot_sum
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dot_sum))
        else $error("held result changed");
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_element |=> o_valid)
        else $error("missing result");
    a_no_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && !o_stall && i_last_element) && !(o_valid && i_stall) |=> !o_valid)
        else $error("invented result");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without result");
endmodule

bind quantized_weight_fp16_dot qwfd_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_last_element(i_last_element), .o_valid(o_valid), .i_stall(i_stall),
    .o_dot_sum(o_dot_sum)
);
